// File: hw/rtl/round_robin_schedule_metrics_defines.svh
// -----------------------------------------------------------------------------
// Round-robin schedule metrics: assertion macros
// Shared property shapes used by the port checker.
// -----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_SCHEDULE_METRICS_DEFINES_SVH
`define ROUND_ROBIN_SCHEDULE_METRICS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RRSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RRSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rrsm_pkg.sv
// -----------------------------------------------------------------------------
// Round-robin schedule metrics package
// Field widths, defaults and the sequencer state type.
// -----------------------------------------------------------------------------
package rrsm_pkg;

  localparam int ARR_W       = 12;
  localparam int BUR_W       = 8;
  localparam int Q_W         = 8;
  localparam int TIME_W      = 13;
  localparam int OUT_IDX_W   = 4;
  localparam int MAX_PROCS_DEF = 16;

  localparam logic [Q_W-1:0]    QUANTUM_RESET = 8'd3;
  localparam logic [TIME_W-1:0] TIME_MAX      = 13'd8191;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_DECIDE,
    ST_POP_RD,
    ST_POP_DATA,
    ST_REM_DATA,
    ST_SLICE,
    ST_OUT_RD,
    ST_OUT_LOAD,
    ST_OUT_HOLD
  } state_t;

endpackage

// File: hw/rtl/rrsm_ram.sv
// -----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// -----------------------------------------------------------------------------
module rrsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/round_robin_schedule_metrics.sv
// -----------------------------------------------------------------------------
// Round-robin schedule metrics
// Loads a process set, simulates round-robin scheduling, reports per-process
// turnaround, waiting and response times.
// -----------------------------------------------------------------------------
// Processes are loaded one item per cycle. The item with last_process set
// starts a tick-by-tick simulation, during which input is stalled. Every tick
// costs one arrival scan over every loaded process through the arrival
// memory's single read port, and every dispatch adds the pop, data and slice
// states. Results then come out one at a time, each held while out_stall is
// high, in index order, after which the block loads the next set.
// The quantum register may be written whenever the block is idle.
module round_robin_schedule_metrics
  import rrsm_pkg::*;
#(
  parameter int MAX_PROCS = MAX_PROCS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [Q_W-1:0]       cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ARR_W-1:0]     in_arrival_time,
  input  logic [BUR_W-1:0]     in_burst_time,
  input  logic                 in_last_process,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_IDX_W-1:0] out_process_index,
  output logic [TIME_W-1:0]    out_turnaround,
  output logic [TIME_W-1:0]    out_waiting,
  output logic [TIME_W-1:0]    out_response,
  output logic                 out_last_result
);

  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int LW = $clog2(MAX_PROCS + 1);
  localparam int TW = $clog2((1 << ARR_W) + MAX_PROCS * (1 << BUR_W));
  localparam logic [IW-1:0] IDX_LAST = IW'(MAX_PROCS - 1);
  localparam logic [LW-1:0] LOAD_MAX = LW'(MAX_PROCS);

  state_t            state_r, state_nxt;
  logic [Q_W-1:0]    quantum_r;
  logic [LW-1:0]     loaded_r, loaded_nxt;
  logic [LW-1:0]     done_r, done_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [IW-1:0]     head_r, head_nxt;
  logic [IW-1:0]     tail_r, tail_nxt;
  logic [LW-1:0]     count_r, count_nxt;
  logic [TW-1:0]     tick_r, tick_nxt;
  logic [IW-1:0]     k_r, k_nxt;
  logic [BUR_W-1:0]  rem_r, rem_nxt;
  logic [Q_W-1:0]    used_r, used_nxt;
  logic              in_slice_r, in_slice_nxt;
  logic [MAX_PROCS-1:0] disp_r, disp_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [TIME_W-1:0]    out_ta_r, out_ta_nxt;
  logic [TIME_W-1:0]    out_wt_r, out_wt_nxt;
  logic [TIME_W-1:0]    out_rs_r, out_rs_nxt;
  logic                 out_last_r, out_last_nxt;

  // Memory controls.
  logic              arr_we, bur_we, rem_we, comp_we, fd_we, ring_we;
  logic [IW-1:0]     load_addr, rem_waddr, rem_raddr, ring_waddr;
  logic [BUR_W-1:0]  rem_wdata;
  logic [IW-1:0]     ring_wdata;
  logic [ARR_W-1:0]  arr_rdata;
  logic [BUR_W-1:0]  bur_rdata, rem_rdata;
  logic [TW-1:0]     comp_rdata, fd_rdata;
  logic [IW-1:0]     ring_rdata;

  logic              in_acc;
  logic              scan_hit;
  logic              scan_end;
  logic              idx_end;
  logic [Q_W-1:0]    q_eff;
  logic [IW-1:0]     head_inc, tail_inc;
  logic [TW-1:0]     ta, wt, rs;
  logic [IW+OUT_IDX_W-1:0] idx_ext;

  assign in_acc    = in_valid && !in_stall;
  assign load_addr = loaded_r[IW-1:0];
  assign q_eff     = (quantum_r == '0) ? Q_W'(1) : quantum_r;
  assign scan_hit  = (tick_r == TW'(arr_rdata));
  assign idx_end   = (LW'(idx_r) == loaded_r - LW'(1));
  assign scan_end  = idx_end;
  assign head_inc  = (head_r == IDX_LAST) ? '0 : head_r + IW'(1);
  assign tail_inc  = (tail_r == IDX_LAST) ? '0 : tail_r + IW'(1);

  // Result arithmetic on the read data of one process.
  assign ta = comp_rdata - TW'(arr_rdata);
  assign wt = (ta >= TW'(bur_rdata)) ? ta - TW'(bur_rdata) : '0;
  assign rs = (fd_rdata >= TW'(arr_rdata)) ? fd_rdata - TW'(arr_rdata) : '0;
  assign idx_ext = {{OUT_IDX_W{1'b0}}, idx_r};

  // Process memories.
  rrsm_ram #(.WIDTH(ARR_W), .DEPTH(MAX_PROCS)) u_arr_ram (
    .clk, .we(arr_we), .waddr(load_addr), .wdata(in_arrival_time),
    .raddr(idx_r), .rdata(arr_rdata)
  );
  rrsm_ram #(.WIDTH(BUR_W), .DEPTH(MAX_PROCS)) u_bur_ram (
    .clk, .we(bur_we), .waddr(load_addr), .wdata(in_burst_time),
    .raddr(idx_r), .rdata(bur_rdata)
  );
  rrsm_ram #(.WIDTH(BUR_W), .DEPTH(MAX_PROCS)) u_rem_ram (
    .clk, .we(rem_we), .waddr(rem_waddr), .wdata(rem_wdata),
    .raddr(rem_raddr), .rdata(rem_rdata)
  );
  rrsm_ram #(.WIDTH(TW), .DEPTH(MAX_PROCS)) u_comp_ram (
    .clk, .we(comp_we), .waddr(k_r), .wdata(tick_r),
    .raddr(idx_r), .rdata(comp_rdata)
  );
  rrsm_ram #(.WIDTH(TW), .DEPTH(MAX_PROCS)) u_fd_ram (
    .clk, .we(fd_we), .waddr(ring_rdata), .wdata(tick_r),
    .raddr(idx_r), .rdata(fd_rdata)
  );
  rrsm_ram #(.WIDTH(IW), .DEPTH(MAX_PROCS)) u_ring_ram (
    .clk, .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
    .raddr(head_r), .rdata(ring_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && in_last_process) begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD:  state_nxt = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        if (scan_end) begin
          state_nxt = in_slice_r ? ST_SLICE : ST_DECIDE;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_DECIDE: begin
        if (done_r == loaded_r) begin
          state_nxt = ST_OUT_RD;
        end else if (count_r != '0) begin
          state_nxt = ST_POP_RD;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_POP_RD:   state_nxt = ST_POP_DATA;
      ST_POP_DATA: state_nxt = ST_REM_DATA;
      ST_REM_DATA: state_nxt = ST_SLICE;
      ST_SLICE: begin
        if (used_r < q_eff && rem_r != '0) begin
          state_nxt = ST_SCAN_RD;
        end else begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_OUT_RD:   state_nxt = ST_OUT_LOAD;
      ST_OUT_LOAD: state_nxt = ST_OUT_HOLD;
      ST_OUT_HOLD: begin
        if (!out_stall) begin
          state_nxt = idx_end ? ST_LOAD : ST_OUT_RD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Memory strobes and handshake outputs.
  always_comb begin
    arr_we     = 1'b0;
    bur_we     = 1'b0;
    rem_we     = 1'b0;
    comp_we    = 1'b0;
    fd_we      = 1'b0;
    ring_we    = 1'b0;
    rem_waddr  = load_addr;
    rem_wdata  = in_burst_time;
    rem_raddr  = ring_rdata;
    ring_waddr = tail_r;
    ring_wdata = idx_r;
    in_stall   = 1'b1;
    case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        if (in_acc && loaded_r < LOAD_MAX) begin
          arr_we = 1'b1;
          bur_we = 1'b1;
          rem_we = 1'b1;
        end
      end
      ST_SCAN_CMP: begin
        ring_we = scan_hit;
      end
      ST_POP_DATA: begin
        fd_we = !disp_r[ring_rdata];
      end
      ST_SLICE: begin
        if (!(used_r < q_eff && rem_r != '0)) begin
          rem_we     = 1'b1;
          rem_waddr  = k_r;
          rem_wdata  = rem_r;
          comp_we    = (rem_r == '0);
          ring_we    = (rem_r != '0);
          ring_wdata = k_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Datapath updates.
  always_comb begin
    loaded_nxt    = loaded_r;
    done_nxt      = done_r;
    idx_nxt       = idx_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    tick_nxt      = tick_r;
    k_nxt         = k_r;
    rem_nxt       = rem_r;
    used_nxt      = used_r;
    in_slice_nxt  = in_slice_r;
    disp_nxt      = disp_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_ta_nxt    = out_ta_r;
    out_wt_nxt    = out_wt_r;
    out_rs_nxt    = out_rs_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (loaded_r < LOAD_MAX) begin
            loaded_nxt = loaded_r + LW'(1);
          end
          if (in_last_process) begin
            tick_nxt     = '0;
            idx_nxt      = '0;
            done_nxt     = '0;
            in_slice_nxt = 1'b0;
          end
        end
      end
      ST_SCAN_CMP: begin
        if (scan_hit) begin
          tail_nxt  = tail_inc;
          count_nxt = count_r + LW'(1);
        end
        idx_nxt = scan_end ? '0 : idx_r + IW'(1);
      end
      ST_DECIDE: begin
        if (done_r == loaded_r) begin
          idx_nxt = '0;
        end else if (count_r == '0) begin
          tick_nxt     = tick_r + TW'(1);
          idx_nxt      = '0;
          in_slice_nxt = 1'b0;
        end
      end
      ST_POP_RD: begin
        head_nxt  = head_inc;
        count_nxt = count_r - LW'(1);
      end
      ST_POP_DATA: begin
        k_nxt = ring_rdata;
        disp_nxt[ring_rdata] = 1'b1;
      end
      ST_REM_DATA: begin
        rem_nxt      = rem_rdata;
        used_nxt     = '0;
        in_slice_nxt = 1'b1;
      end
      ST_SLICE: begin
        if (used_r < q_eff && rem_r != '0) begin
          rem_nxt  = rem_r - BUR_W'(1);
          tick_nxt = tick_r + TW'(1);
          used_nxt = used_r + Q_W'(1);
          idx_nxt  = '0;
        end else begin
          in_slice_nxt = 1'b0;
          if (rem_r == '0) begin
            done_nxt = done_r + LW'(1);
          end else begin
            tail_nxt  = tail_inc;
            count_nxt = count_r + LW'(1);
          end
        end
      end
      ST_OUT_LOAD: begin
        out_valid_nxt = 1'b1;
        out_idx_nxt   = idx_ext[OUT_IDX_W-1:0];
        out_ta_nxt    = (ta > TW'(TIME_MAX)) ? TIME_MAX : ta[TIME_W-1:0];
        out_wt_nxt    = (wt > TW'(TIME_MAX)) ? TIME_MAX : wt[TIME_W-1:0];
        out_rs_nxt    = (rs > TW'(TIME_MAX)) ? TIME_MAX : rs[TIME_W-1:0];
        out_last_nxt  = idx_end;
      end
      ST_OUT_HOLD: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (idx_end) begin
            loaded_nxt = '0;
            head_nxt   = '0;
            tail_nxt   = '0;
            count_nxt  = '0;
            tick_nxt   = '0;
            disp_nxt   = '0;
            idx_nxt    = '0;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      quantum_r   <= QUANTUM_RESET;
      loaded_r    <= '0;
      done_r      <= '0;
      idx_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      tick_r      <= '0;
      in_slice_r  <= 1'b0;
      disp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        quantum_r <= cfg_data;
      end
      loaded_r    <= loaded_nxt;
      done_r      <= done_nxt;
      idx_r       <= idx_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      tick_r      <= tick_nxt;
      in_slice_r  <= in_slice_nxt;
      disp_r      <= disp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    rem_r      <= rem_nxt;
    used_r     <= used_nxt;
    out_idx_r  <= out_idx_nxt;
    out_ta_r   <= out_ta_nxt;
    out_wt_r   <= out_wt_nxt;
    out_rs_r   <= out_rs_nxt;
    out_last_r <= out_last_nxt;
  end

  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_process_index = out_idx_r;
  assign out_turnaround    = out_ta_r;
  assign out_waiting       = out_wt_r;
  assign out_response      = out_rs_r;
  assign out_last_result   = out_last_r;

endmodule

// File: hw/rtl/rrsm_checker.sv
// -----------------------------------------------------------------------------
// Round-robin schedule metrics port checker
// Watches the top-level ports for ordering of loading and reporting.
// -----------------------------------------------------------------------------
`include "round_robin_schedule_metrics_defines.svh"

module rrsm_checker
  import rrsm_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [Q_W-1:0]       cfg_data,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [ARR_W-1:0]     in_arrival_time,
  input logic [BUR_W-1:0]     in_burst_time,
  input logic                 in_last_process,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [OUT_IDX_W-1:0] out_process_index,
  input logic [TIME_W-1:0]    out_turnaround,
  input logic [TIME_W-1:0]    out_waiting,
  input logic [TIME_W-1:0]    out_response,
  input logic                 out_last_result
);

  // Loading and reporting never overlap.
  `RRSM_ASSERT_NOW(a_no_load_while_report, !in_stall, !out_valid, "load during report")

  // The last process of a set closes the input until its results are out.
  `RRSM_ASSERT_NEXT(a_last_closes_input, in_valid && !in_stall && in_last_process, in_stall, "input open after last process")

  // Nothing follows the final result of a set.
  `RRSM_ASSERT_NEXT(a_final_result_ends, out_valid && !out_stall && out_last_result, !out_valid, "result after final result")

  // A stalled result holds its index.
  `RRSM_ASSERT_NEXT(a_stalled_index_holds, out_valid && out_stall, out_valid && $stable(out_process_index), "stalled result changed")

endmodule

bind round_robin_schedule_metrics rrsm_checker u_rrsm_checker (.*);
